// ----- rtl/lcdws_pkg.sv -----
package lcdws_pkg;

    // Input operation codes.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_INSTR = 2'd1;
    localparam logic [1:0] OP_DATA  = 2'd2;
    localparam logic [1:0] OP_INIT  = 2'd3;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_ENABLE_HIGH = 2'd0;
    localparam logic [1:0] REG_INSTR_GAP   = 2'd1;
    localparam logic [1:0] REG_LONG_GAP    = 2'd2;
    localparam logic [1:0] REG_POWER_UP    = 2'd3;

    // Register reset values.
    localparam logic [7:0]  ENABLE_HIGH_RST = 8'd5;
    localparam logic [9:0]  INSTR_GAP_RST   = 10'd40;
    localparam logic [15:0] LONG_GAP_RST    = 16'd1600;
    localparam logic [15:0] POWER_UP_RST    = 16'd40000;

    // Instructions that need the long gap.
    localparam logic [7:0] INSTR_CLEAR = 8'h01;
    localparam logic [7:0] INSTR_HOME  = 8'h02;

    // Power-on sequence: four single nibbles, then five instruction bytes.
    localparam logic [3:0] INIT_ITEMS     = 4'd9;
    localparam logic [3:0] INIT_NIBBLES   = 4'd4;

    typedef struct packed {
        logic [7:0]  enable_high_ticks;
        logic [9:0]  instruction_gap_ticks;
        logic [15:0] long_gap_ticks;
        logic [15:0] power_up_ticks;
    } cfg_t;

    typedef struct packed {
        logic       rejected;
        logic       busy_res;
        logic [3:0] data_pins;
        logic       select_pin;
        logic       enable_pin;
    } result_t;

    // Byte or nibble sent at each step of the power-on sequence.
    function automatic logic [7:0] init_item(input logic [3:0] idx);
        logic [7:0] item;
        begin
            case (idx)
                4'd0:    item = 8'h03;
                4'd1:    item = 8'h03;
                4'd2:    item = 8'h03;
                4'd3:    item = 8'h02;
                4'd4:    item = 8'h28;
                4'd5:    item = 8'h08;
                4'd6:    item = 8'h01;
                4'd7:    item = 8'h06;
                4'd8:    item = 8'h0C;
                default: item = 8'h00;
            endcase
            return item;
        end
    endfunction

endpackage

// ----- rtl/lcdws_cfg.sv -----
module lcdws_cfg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output lcdws_pkg::cfg_t      cfg
);

    lcdws_pkg::cfg_t cfg_reg;
    logic            wr_en;
    logic [1:0]      reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    // Register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable_high_ticks     <= lcdws_pkg::ENABLE_HIGH_RST;
            cfg_reg.instruction_gap_ticks <= lcdws_pkg::INSTR_GAP_RST;
            cfg_reg.long_gap_ticks        <= lcdws_pkg::LONG_GAP_RST;
            cfg_reg.power_up_ticks        <= lcdws_pkg::POWER_UP_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                lcdws_pkg::REG_ENABLE_HIGH: cfg_reg.enable_high_ticks <= pwdata[7:0];
                lcdws_pkg::REG_INSTR_GAP:   cfg_reg.instruction_gap_ticks <= pwdata[9:0];
                lcdws_pkg::REG_LONG_GAP:    cfg_reg.long_gap_ticks <= pwdata[15:0];
                lcdws_pkg::REG_POWER_UP:    cfg_reg.power_up_ticks <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read data.
    always_comb begin
        unique case (reg_idx)
            lcdws_pkg::REG_ENABLE_HIGH: prdata = {24'd0, cfg_reg.enable_high_ticks};
            lcdws_pkg::REG_INSTR_GAP:   prdata = {22'd0, cfg_reg.instruction_gap_ticks};
            lcdws_pkg::REG_LONG_GAP:    prdata = {16'd0, cfg_reg.long_gap_ticks};
            lcdws_pkg::REG_POWER_UP:    prdata = {16'd0, cfg_reg.power_up_ticks};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

// ----- rtl/lcdws_core.sv -----
module lcdws_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  logic [1:0]           op,
    input  logic [7:0]           value,
    input  lcdws_pkg::cfg_t      cfg,
    output lcdws_pkg::result_t   res
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_POWER   = 3'd1;
    localparam logic [2:0] PH_EN_HIGH = 3'd2;
    localparam logic [2:0] PH_EN_LOW  = 3'd3;
    localparam logic [2:0] PH_GAP     = 3'd4;
    localparam logic [2:0] PH_LONG    = 3'd5;

    logic [2:0]  phase_reg, phase_next, phase_cur;
    logic [15:0] wait_reg, wait_next, wait_dec;
    logic [7:0]  pending_reg, pending_next;
    logic        low_next_reg, low_next_next;
    logic        long_pend_reg, long_pend_next;
    logic [3:0]  init_step_reg, init_step_next;
    logic        select_reg, select_next;
    logic        enable_reg, enable_next;
    logic [3:0]  data_reg, data_next;
    logic        rej;

    logic [15:0] ehi_ticks, gap_ticks, long_ticks, pwr_ticks;

    logic        cont_seq;
    logic        launch_init;
    logic [3:0]  launch_idx;
    logic [7:0]  launch_item;
    logic        start_byte;
    logic [7:0]  byte_val;
    logic        byte_rs;
    logic        start_nib;
    logic [3:0]  nib_val;

    // A zero timing register counts as one tick.
    assign ehi_ticks  = (cfg.enable_high_ticks == 8'd0) ? 16'd1
                        : {8'd0, cfg.enable_high_ticks};
    assign gap_ticks  = (cfg.instruction_gap_ticks == 10'd0) ? 16'd1
                        : {6'd0, cfg.instruction_gap_ticks};
    assign long_ticks = (cfg.long_gap_ticks == 16'd0) ? 16'd1 : cfg.long_gap_ticks;
    assign pwr_ticks  = (cfg.power_up_ticks == 16'd0) ? 16'd1 : cfg.power_up_ticks;

    assign phase_cur   = (phase_reg > PH_LONG) ? PH_IDLE : phase_reg;
    assign wait_dec    = wait_reg - 16'd1;
    assign launch_item = lcdws_pkg::init_item(launch_idx);

    // Next state for one word: tick handling, then sequence continuation,
    // then starting a byte, then raising EN with a nibble.
    always_comb begin
        phase_next     = phase_cur;
        wait_next      = wait_reg;
        pending_next   = pending_reg;
        low_next_next  = low_next_reg;
        long_pend_next = long_pend_reg;
        init_step_next = init_step_reg;
        select_next    = select_reg;
        enable_next    = enable_reg;
        data_next      = data_reg;
        rej            = 1'b0;
        cont_seq       = 1'b0;
        launch_init    = 1'b0;
        launch_idx     = 4'd0;
        start_byte     = 1'b0;
        byte_val       = 8'd0;
        byte_rs        = 1'b0;
        start_nib      = 1'b0;
        nib_val        = 4'd0;

        if (op == lcdws_pkg::OP_TICK) begin
            unique case (phase_cur)
                PH_POWER: begin
                    wait_next = wait_dec;
                    if (wait_dec == 16'd0) begin
                        init_step_next = 4'd1;
                        launch_init    = 1'b1;
                        launch_idx     = 4'd0;
                    end
                end
                PH_EN_HIGH: begin
                    wait_next = wait_dec;
                    if (wait_dec == 16'd0) begin
                        enable_next = 1'b0;
                        if (low_next_reg) begin
                            phase_next = PH_EN_LOW;
                        end else begin
                            wait_next  = gap_ticks;
                            phase_next = PH_GAP;
                        end
                    end
                end
                PH_EN_LOW: begin
                    low_next_next = 1'b0;
                    start_nib     = 1'b1;
                    nib_val       = pending_reg[3:0];
                end
                PH_GAP: begin
                    wait_next = wait_dec;
                    if (wait_dec == 16'd0) begin
                        if (long_pend_reg) begin
                            long_pend_next = 1'b0;
                            wait_next      = long_ticks;
                            phase_next     = PH_LONG;
                        end else begin
                            cont_seq = 1'b1;
                        end
                    end
                end
                PH_LONG: begin
                    wait_next = wait_dec;
                    if (wait_dec == 16'd0) begin
                        cont_seq = 1'b1;
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end else if (phase_cur != PH_IDLE) begin
            rej = 1'b1;
        end else if (op == lcdws_pkg::OP_INSTR) begin
            start_byte = 1'b1;
            byte_val   = value;
            byte_rs    = 1'b0;
        end else if (op == lcdws_pkg::OP_DATA) begin
            start_byte = 1'b1;
            byte_val   = value;
            byte_rs    = 1'b1;
        end else begin
            init_step_next = 4'd0;
            select_next    = 1'b0;
            enable_next    = 1'b0;
            low_next_next  = 1'b0;
            long_pend_next = 1'b0;
            wait_next      = pwr_ticks;
            phase_next     = PH_POWER;
        end

        // Move on to the next power-on item, or go idle.
        if (cont_seq) begin
            if (init_step_reg != 4'd0 && init_step_reg < lcdws_pkg::INIT_ITEMS) begin
                init_step_next = init_step_reg + 4'd1;
                launch_init    = 1'b1;
                launch_idx     = init_step_reg;
            end else begin
                init_step_next = 4'd0;
                phase_next     = PH_IDLE;
            end
        end

        // Power-on items: single nibbles first, then whole instruction bytes.
        if (launch_init) begin
            if (launch_idx >= lcdws_pkg::INIT_ITEMS) begin
                phase_next = PH_IDLE;
            end else if (launch_idx < lcdws_pkg::INIT_NIBBLES) begin
                select_next    = 1'b0;
                low_next_next  = 1'b0;
                long_pend_next = 1'b0;
                start_nib      = 1'b1;
                nib_val        = launch_item[3:0];
            end else begin
                start_byte = 1'b1;
                byte_val   = launch_item;
                byte_rs    = 1'b0;
            end
        end

        // A byte goes out high nibble first.
        if (start_byte) begin
            pending_next   = byte_val;
            select_next    = byte_rs;
            low_next_next  = 1'b1;
            long_pend_next = !byte_rs && (byte_val == lcdws_pkg::INSTR_CLEAR ||
                                          byte_val == lcdws_pkg::INSTR_HOME);
            start_nib      = 1'b1;
            nib_val        = byte_val[7:4];
        end

        if (start_nib) begin
            data_next   = nib_val;
            enable_next = 1'b1;
            wait_next   = ehi_ticks;
            phase_next  = PH_EN_HIGH;
        end
    end

    // Pin levels after this word.
    assign res.enable_pin = enable_next;
    assign res.select_pin = select_next;
    assign res.data_pins  = data_next;
    assign res.busy_res   = (phase_next != PH_IDLE);
    assign res.rejected   = rej;

    // Sequencer state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            wait_reg      <= 16'd0;
            pending_reg   <= 8'd0;
            low_next_reg  <= 1'b0;
            long_pend_reg <= 1'b0;
            init_step_reg <= 4'd0;
            select_reg    <= 1'b0;
            enable_reg    <= 1'b0;
            data_reg      <= 4'd0;
        end else if (step_en) begin
            phase_reg     <= phase_next;
            wait_reg      <= wait_next;
            pending_reg   <= pending_next;
            low_next_reg  <= low_next_next;
            long_pend_reg <= long_pend_next;
            init_step_reg <= init_step_next;
            select_reg    <= select_next;
            enable_reg    <= enable_next;
            data_reg      <= data_next;
        end
    end

    // A dropped command leaves the sequencer busy.
    a_reject_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && res.rejected |-> res.busy_res)
        else $error("rejected command reported while idle");

    // EN is high exactly while a nibble is being strobed.
    a_enable_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        enable_reg == (phase_reg == PH_EN_HIGH))
        else $error("EN level does not match phase");

    // The power-on step count only runs while the sequencer is busy and never passes the item count.
    a_init_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        init_step_reg != 4'd0 |-> phase_reg != PH_IDLE && init_step_reg <= lcdws_pkg::INIT_ITEMS)
        else $error("power-on step out of range");

    // Timed phases always hold a nonzero count.
    a_wait_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_POWER || phase_reg == PH_EN_HIGH || phase_reg == PH_GAP ||
         phase_reg == PH_LONG) |-> wait_reg != 16'd0)
        else $error("timed phase with empty counter");

endmodule

// ----- rtl/char_lcd_4bit_write_sequencer.sv -----
// Four-bit write sequencer for a character LCD.
// Input stream (s_axis): each word is either a one-microsecond tick or a
// command (send instruction byte, send data byte, start power-on sequence).
// Result stream (m_axis): one word per input word, giving the EN, RS and
// DB7..DB4 levels after that word, a busy flag and a rejected flag that is
// set when a command arrived while the sequencer was busy.
// Timing registers (EN high time, instruction gap, long gap after clear or
// home, power-up wait) sit on the APB port at byte addresses 0, 4, 8 and 12,
// counted in ticks; a zero register acts as one tick.
// A word accepted into the input register moves through the next-state
// logic into the result register, whose word is offered on m_axis until
// it is taken. Throughput is one word per cycle while the receiver does
// not stall, as the sequencer state updates once for each word that advances.
// When the receiver stalls, the result register holds its word and the
// input register takes one more word, after which s_axis_tready drops.
// Reset clears both stages and puts the sequencer idle with all pins low
// and the timing registers at their defaults.
module char_lcd_4bit_write_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [1:0] op, [9:2] value, [15:10] zero
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] enable_pin, [1] select_pin,
                                        // [5:2] data_pins, [6] busy_res, [7] rejected
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic               in_valid_reg;
    logic [1:0]         in_op_reg;
    logic [7:0]         in_value_reg;
    logic               out_valid_reg;
    lcdws_pkg::result_t out_data_reg;
    logic               in_accept;
    logic               advance;
    lcdws_pkg::cfg_t    cfg;
    lcdws_pkg::result_t res;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    lcdws_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lcdws_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .op      (in_op_reg),
        .value   (in_value_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_op_reg    <= s_axis_tdata[1:0];
            in_value_reg <= s_axis_tdata[9:2];
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= res;
        end
    end

    // A held input word is never lost while the result side stalls.
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_op_reg) &&
        $stable(in_value_reg))
        else $error("input word lost during stall");

    // Each processed word lands in the result register.
    a_advance_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("processed word did not reach the result register");

    // A waiting result is not overwritten.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_axis_tready |-> !advance)
        else $error("result overwritten while stalled");

endmodule
